FILE: rtl/tsda_pkg.sv
// Shared types and constants for the touch sample debounce and average block.
`default_nettype none
package tsda_pkg;

  localparam int unsigned SmpW = 12;
  localparam int unsigned SumW = 16;
  localparam int unsigned ReadW = 7;
  localparam int unsigned RepW = 4;
  localparam int unsigned RetryW = 6;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 12;

  localparam logic [SmpW-1:0] RAIL_HIGH = 12'hFFF;
  localparam logic [SumW-1:0] SUM_MAX = 16'hFFFF;
  localparam logic [ReadW-1:0] READ_MAX = 7'd127;
  localparam logic [RepW-1:0] REP_MAX = 4'd15;

  localparam logic [SmpW-1:0] TOL_RESET = 12'd10;
  localparam logic [RetryW-1:0] RETRY_RESET = 6'd10;
  localparam logic [RepW-1:0] REPEAT_RESET = 4'd5;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TOLERANCE = 2'd0,
    CFG_RETRY_LIMIT = 2'd1,
    CFG_REPEAT_NEEDED = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ACT_REPEAT = 2'd0,
    ACT_IGNORE = 2'd1,
    ACT_ACCEPT = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_RESULT
  } state_e;

  typedef struct packed {
    logic start;
    logic done;
  } div_ctrl_t;

endpackage
`default_nettype wire

FILE: rtl/tsda_in_if.sv
// Input channel: coordinate select and raw sample with valid/ready.
`default_nettype none
interface tsda_in_if;
  logic        valid;
  logic        ready;
  logic        coord_select;
  logic [11:0] sample;

  modport source (output valid, output coord_select, output sample, input ready);
  modport sink (input valid, input coord_select, input sample, output ready);
endinterface
`default_nettype wire

FILE: rtl/tsda_out_if.sv
// Result channel: action code and value with valid/ready.
`default_nettype none
interface tsda_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [11:0] value;

  modport source (output valid, output action, output value, input ready);
  modport sink (input valid, input action, input value, output ready);
endinterface
`default_nettype wire

FILE: rtl/tsda_div.sv
// Bit-serial restoring divider: one quotient bit per cycle.
`default_nettype none
module tsda_div (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [tsda_pkg::SumW-1:0]  dividend_i,
  input  wire logic [tsda_pkg::RepW-1:0]  divisor_i,
  output logic                            done_o,
  output logic [tsda_pkg::SumW-1:0]       quotient_o
);
  import tsda_pkg::*;

  localparam int unsigned CntW = $clog2(SumW);

  logic                busy_q;
  logic                done_q;
  logic [CntW-1:0]     cnt_q;
  logic [RepW-1:0]     rem_q;
  logic [RepW-1:0]     dsr_q;
  logic [SumW-1:0]     quo_q;
  logic [RepW:0]       trial;
  logic                ge;
  logic [RepW:0]       diff;

  assign trial = {rem_q, quo_q[SumW-1]};
  assign ge    = trial >= {1'b0, dsr_q};
  assign diff  = trial - {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(SumW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dsr_q <= divisor_i;
      quo_q <= dividend_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[RepW-1:0] : trial[RepW-1:0];
      quo_q <= {quo_q[SumW-2:0], ge};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;
endmodule
`default_nettype wire

FILE: rtl/touch_sample_debounce_average.sv
// Top level: debounce state, run control and result register.
//
//   channel      dir  payload                        handshake
//   sample_in_i  in   coord_select[0], sample[11:0]   valid/ready
//   result_o     out  action[1:0], value[11:0]        valid/ready
//   cfg          in   cfg_idx_i[1:0], cfg_wdata_i     cfg_we_i
//
// Repeat and ignore results pass through the update and the result stage.
// Accept results pass through the update, the 16-step bit-serial divider and the result stage.
// Reset clears counters, reference, sums and loads register defaults.
// A waiting result sits in the output register while the next sample is taken.
`default_nettype none
module touch_sample_debounce_average (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  tsda_in_if.sink                            sample_in_i,
  tsda_out_if.source                         result_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [tsda_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [tsda_pkg::CfgDataW-1:0] cfg_wdata_i
);
  import tsda_pkg::*;

  logic [SmpW-1:0]   tol_q;
  logic [RetryW-1:0] retry_q;
  logic [RepW-1:0]   repeat_q;

  logic [ReadW-1:0]  read_q, read_d;
  logic [RepW-1:0]   rep_q, rep_d;
  logic [SmpW-1:0]   ref_q, ref_d;
  logic [SumW-1:0]   sum0_q, sum0_d, sum1_q, sum1_d;

  state_e            state_q, state_d;
  action_e           res_act_q, res_act_d;
  logic [SmpW-1:0]   res_val_q, res_val_d;
  logic              out_valid_q;
  action_e           out_act_q;
  logic [SmpW-1:0]   out_val_q;

  logic              accept;
  logic              go_div;
  logic              load_out;
  logic              sel;
  logic [SmpW-1:0]   smp;
  logic [SmpW-1:0]   diff;
  logic [SumW-1:0]   sum_cur;
  logic [SumW:0]     sum_add;
  logic [SumW-1:0]   sum_new;
  logic [RepW-1:0]   rep_new;
  logic [ReadW-1:0]  read_inc;
  logic [RepW-1:0]   divisor;
  logic [SumW-1:0]   quotient;
  logic [SmpW-1:0]   avg_sat;
  logic              div_start;
  logic              div_done;

  assign sel      = sample_in_i.coord_select;
  assign smp      = sample_in_i.sample;
  assign accept   = sample_in_i.valid && sample_in_i.ready;
  assign diff     = (ref_q > smp) ? (ref_q - smp) : (smp - ref_q);
  assign sum_cur  = sel ? sum1_q : sum0_q;
  assign sum_add  = {1'b0, sum_cur} + {{(SumW + 1 - SmpW){1'b0}}, smp};
  assign sum_new  = sum_add[SumW] ? SUM_MAX : sum_add[SumW-1:0];
  assign rep_new  = (rep_q < REP_MAX) ? rep_q + 1'b1 : REP_MAX;
  assign read_inc = (read_q < READ_MAX) ? read_q + 1'b1 : READ_MAX;
  assign divisor  = (repeat_q == '0) ? RepW'(1) : repeat_q;
  assign avg_sat  = (|quotient[SumW-1:SmpW]) ? RAIL_HIGH : quotient[SmpW-1:0];

  // run update on an accepted sample
  always_comb begin
    read_d    = read_q;
    rep_d     = rep_q;
    ref_d     = ref_q;
    sum0_d    = sum0_q;
    sum1_d    = sum1_q;
    res_act_d = ACT_REPEAT;
    res_val_d = smp;
    go_div    = 1'b0;
    if (read_q == '0) begin
      read_d = ReadW'(1);
    end else if (smp == RAIL_HIGH || smp == '0) begin
      read_d    = '0;
      ref_d     = '0;
      sum0_d    = '0;
      sum1_d    = '0;
      res_act_d = ACT_IGNORE;
    end else if (read_q == ReadW'(1) || diff > tol_q) begin
      rep_d = RepW'(1);
      if (read_q < {1'b0, retry_q}) begin
        ref_d  = smp;
        read_d = read_inc;
        if (sel) begin
          sum1_d = {{(SumW - SmpW){1'b0}}, smp};
        end else begin
          sum0_d = {{(SumW - SmpW){1'b0}}, smp};
        end
      end else begin
        read_d    = '0;
        ref_d     = '0;
        sum0_d    = '0;
        sum1_d    = '0;
        res_act_d = ACT_IGNORE;
      end
    end else begin
      if (sel) begin
        sum1_d = sum_new;
      end else begin
        sum0_d = sum_new;
      end
      if (rep_new >= repeat_q) begin
        read_d    = '0;
        rep_d     = '0;
        ref_d     = '0;
        res_act_d = ACT_ACCEPT;
        go_div    = 1'b1;
      end else begin
        rep_d  = rep_new;
        read_d = read_inc;
      end
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = go_div ? ST_DIV : ST_RESULT;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (!out_valid_q || result_o.ready) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    sample_in_i.ready = 1'b0;
    load_out          = 1'b0;
    div_start         = 1'b0;
    case (state_q)
      ST_IDLE: begin
        sample_in_i.ready = 1'b1;
        div_start         = accept && go_div;
      end
      ST_RESULT: begin
        load_out = !out_valid_q || result_o.ready;
      end
      default: begin
        sample_in_i.ready = 1'b0;
      end
    endcase
  end

  tsda_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_new),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q       <= TOL_RESET;
      retry_q     <= RETRY_RESET;
      repeat_q    <= REPEAT_RESET;
      read_q      <= '0;
      rep_q       <= '0;
      ref_q       <= '0;
      sum0_q      <= '0;
      sum1_q      <= '0;
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_TOLERANCE:     tol_q    <= cfg_wdata_i[SmpW-1:0];
          CFG_RETRY_LIMIT:   retry_q  <= cfg_wdata_i[RetryW-1:0];
          CFG_REPEAT_NEEDED: repeat_q <= cfg_wdata_i[RepW-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        read_q <= read_d;
        rep_q  <= rep_d;
        ref_q  <= ref_d;
        sum0_q <= sum0_d;
        sum1_q <= sum1_d;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_act_q <= res_act_d;
      res_val_q <= res_val_d;
    end else if (div_done) begin
      res_val_q <= avg_sat;
    end
    if (load_out) begin
      out_act_q <= res_act_q;
      out_val_q <= res_val_q;
    end
  end

  assign result_o.valid  = out_valid_q;
  assign result_o.action = out_act_q;
  assign result_o.value  = out_val_q;
endmodule
`default_nettype wire

FILE: sim/touch_sample_debounce_average_tb.sv
// Testbench for touch_sample_debounce_average: predicts repeat/ignore/accept results per sample.
`timescale 1ns / 1ps
module touch_sample_debounce_average_tb;
  import tsda_pkg::*;

  localparam int unsigned IdleLimit = 2000;
  localparam int unsigned PhaseItems = 60;

  typedef struct {
    logic            sel;
    logic [SmpW-1:0] smp;
  } touch_sample_t;

  typedef struct {
    action_e         act;
    logic [SmpW-1:0] value;
  } verdict_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;

  tsda_in_if  sample_if ();
  tsda_out_if result_if ();

  touch_sample_debounce_average u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .sample_in_i (sample_if),
    .result_o    (result_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #6 clk_i = ~clk_i;

  // filter settings and debounce state mirrored from the block
  logic [SmpW-1:0]   tol = TOL_RESET;
  logic [RetryW-1:0] retry = RETRY_RESET;
  logic [RepW-1:0]   rep_need = REPEAT_RESET;
  logic [ReadW-1:0]  rd_cnt = '0;
  logic [RepW-1:0]   rep_cnt = '0;
  logic [SmpW-1:0]   ref_reading = '0;
  logic [SumW-1:0]   coord_sum [2] = '{default: '0};

  touch_sample_t sample_q [$];
  verdict_t      verdict_q [$];
  int unsigned   pushed_cnt = 0;
  int unsigned   taken_cnt = 0;
  int unsigned   err_cnt = 0;
  int unsigned   n_setting = 0;
  int unsigned   n_repeat = 0;
  int unsigned   n_ignore = 0;
  int unsigned   n_accept = 0;
  int unsigned   idle_cycles = 0;
  bit            quiet = 1'b0;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    err_cnt++;
  endtask

  function automatic void abort_measurement();
    rd_cnt = '0;
    ref_reading = '0;
    coord_sum[0] = '0;
    coord_sum[1] = '0;
  endfunction

  function automatic void debounce_filter(input logic sel, input logic [SmpW-1:0] smp);
    verdict_t         v;
    logic [SmpW-1:0]  diff;
    logic [SumW:0]    acc;
    logic [SumW-1:0]  avg;
    logic [RepW-1:0]  divisor;
    v.act = ACT_REPEAT;
    v.value = smp;
    diff = (ref_reading > smp) ? ref_reading - smp : smp - ref_reading;
    if (rd_cnt == '0) begin
      rd_cnt = ReadW'(1);
    end else if (smp == RAIL_HIGH || smp == '0) begin
      abort_measurement();
      v.act = ACT_IGNORE;
    end else if (rd_cnt == ReadW'(1) || diff > tol) begin
      rep_cnt = RepW'(1);
      coord_sum[sel] = {{(SumW-SmpW){1'b0}}, smp};
      if (rd_cnt < {1'b0, retry}) begin
        ref_reading = smp;
        if (rd_cnt != READ_MAX) rd_cnt++;
      end else begin
        abort_measurement();
        v.act = ACT_IGNORE;
      end
    end else begin
      acc = coord_sum[sel] + smp;
      coord_sum[sel] = (acc > SUM_MAX) ? SUM_MAX : acc[SumW-1:0];
      if (rep_cnt != REP_MAX) rep_cnt++;
      if (rep_cnt >= rep_need) begin
        divisor = (rep_need == '0) ? RepW'(1) : rep_need;
        avg = coord_sum[sel] / divisor;
        rd_cnt = '0;
        rep_cnt = '0;
        ref_reading = '0;
        v.value = (avg > RAIL_HIGH) ? RAIL_HIGH : avg[SmpW-1:0];
        v.act = ACT_ACCEPT;
      end else if (rd_cnt != READ_MAX) begin
        rd_cnt++;
      end
    end
    verdict_q.push_back(v);
  endfunction

  // sample driver
  always @(posedge clk_i or negedge rst_ni) begin
    touch_sample_t t;
    if (!rst_ni) begin
      sample_if.valid <= 1'b0;
      sample_if.coord_select <= 1'b0;
      sample_if.sample <= '0;
    end else begin
      if (sample_if.valid && sample_if.ready) begin
        debounce_filter(sample_if.coord_select, sample_if.sample);
        taken_cnt++;
      end
      if (!sample_if.valid || sample_if.ready) begin
        if (sample_q.size() != 0 && (quiet || $urandom_range(99) >= 9)) begin
          t = sample_q.pop_front();
          sample_if.valid <= 1'b1;
          sample_if.coord_select <= t.sel;
          sample_if.sample <= t.smp;
        end else begin
          sample_if.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    verdict_t v;
    if (!rst_ni) begin
      result_if.ready <= 1'b0;
    end else begin
      if (result_if.valid && result_if.ready) begin
        if (verdict_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result action=%0d value=%0d",
                                    result_if.action, result_if.value));
        end else begin
          v = verdict_q.pop_front();
          if (result_if.action !== v.act)
            report_mismatch($sformatf("action %0d, expected %s",
                                      result_if.action, v.act.name()));
          if (result_if.value !== v.value)
            report_mismatch($sformatf("value %0d, expected %0d", result_if.value, v.value));
          case (v.act)
            ACT_ACCEPT: n_accept++;
            ACT_IGNORE: n_ignore++;
            default: n_repeat++;
          endcase
        end
      end
      result_if.ready <= quiet || ($urandom_range(99) >= 9);
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((sample_if.valid && sample_if.ready) || (result_if.valid && result_if.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("touch_sample_debounce_average test failed");
        $finish;
      end
    end
  end

  task automatic push_sample(input logic sel, input logic [SmpW-1:0] smp);
    touch_sample_t t;
    t.sel = sel;
    t.smp = smp;
    sample_q.push_back(t);
    pushed_cnt++;
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_TOLERANCE: tol = data;
      CFG_RETRY_LIMIT: retry = data[RetryW-1:0];
      CFG_REPEAT_NEEDED: rep_need = data[RepW-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_setting(input int t, input int r, input int n);
    write_reg(CFG_TOLERANCE, CfgDataW'(t));
    write_reg(CFG_RETRY_LIMIT, CfgDataW'(r));
    write_reg(CFG_REPEAT_NEEDED, CfgDataW'(n));
    n_setting++;
  endtask

  // one measurement: discarded first read, then a rail read, or an anchor read and readings mostly near the anchor
  task automatic push_run();
    logic sel;
    int   base;
    int   lo;
    int   hi;
    int   n;
    sel = 1'($urandom_range(1));
    push_sample(sel, SmpW'($urandom_range(4095)));
    if ($urandom_range(99) < 8) begin
      push_sample(sel, $urandom_range(1) ? RAIL_HIGH : '0);
      return;
    end
    base = int'($urandom_range(4094, 1));
    push_sample(sel, SmpW'(base));
    lo = base - int'(tol);
    hi = base + int'(tol);
    if (lo < 1) lo = 1;
    if (hi > 4094) hi = 4094;
    n = (rep_need <= 1) ? 1 : int'(rep_need) - 1;
    if ($urandom_range(3) == 0) sel = ~sel;
    repeat (n) begin
      case ($urandom_range(24))
        0: push_sample(sel, SmpW'($urandom_range(4095)));
        1: push_sample(sel, $urandom_range(1) ? RAIL_HIGH : '0);
        2: push_sample(~sel, SmpW'($urandom_range(hi, lo)));
        default: push_sample(sel, SmpW'($urandom_range(hi, lo)));
      endcase
    end
  endtask

  task automatic drain();
    while (taken_cnt != pushed_cnt || verdict_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic random_phase();
    int unsigned start;
    start = pushed_cnt;
    while (pushed_cnt - start < PhaseItems) push_run();
    drain();
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_TOLERANCE;
    cfg_wdata_i = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: rails, tolerance edge, coordinate switch, accept, retry abort
    push_sample(1'b0, 12'd4095);
    push_sample(1'b0, 12'd0);
    push_sample(1'b1, 12'd0);
    push_sample(1'b1, 12'd4095);
    push_sample(1'b0, 12'd2000);
    push_sample(1'b0, 12'd2000);
    push_sample(1'b0, 12'd2010);
    push_sample(1'b0, 12'd1990);
    push_sample(1'b1, 12'd2005);
    push_sample(1'b0, 12'd2000);
    push_sample(1'b1, 12'd1);
    push_sample(1'b1, 12'd4094);
    push_sample(1'b1, 12'd4083);
    for (int i = 0; i < 8; i++) push_sample(i[0], i[0] ? 12'd3000 : 12'd100);
    drain();

    quiet = 1'b1;
    apply_setting(TOL_RESET, RETRY_RESET, REPEAT_RESET);
    random_phase();
    quiet = 1'b0;
    apply_setting(0, 1, 1);
    random_phase();
    apply_setting(4095, 63, 15);
    random_phase();
    apply_setting(0, 0, 0);
    random_phase();
    apply_setting(4095, 63, 0);
    random_phase();
    repeat (3) begin
      apply_setting($urandom_range(200), $urandom_range(63, 1), $urandom_range(15, 1));
      random_phase();
    end

    repeat (40) @(posedge clk_i);
    if (verdict_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", verdict_q.size()));
    $display("Covered %0d samples over %0d register settings plus reset defaults.",
             taken_cnt, n_setting);
    $display("Results: %0d accept, %0d ignore, %0d repeat; %0d mismatches.",
             n_accept, n_ignore, n_repeat, err_cnt);
    if (err_cnt == 0) begin
      $display("touch_sample_debounce_average test passed");
    end else begin
      $display("touch_sample_debounce_average test failed");
    end
    $finish;
  end

endmodule
